[src/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Shared constants, codes and types for the sorted table binary search unit.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int DEPTH  = 1024;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int SIZE_W = IDX_W + 1;
   localparam int CFG_W  = 11;
   localparam int POS_W  = 10;
   localparam int WORD_W = 32;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [WORD_W-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } mem_req_type;

endpackage

[src/sbs_table_ram.sv]
// ----------------------------------------------------------------------------
// Sorted table memory
// Single write port, single read port table storage with a registered read.
// ----------------------------------------------------------------------------
module sbs_table_ram (
   input  logic                             clock,
   input  sbs_pkg::mem_req_type             mem_req,
   output logic signed [sbs_pkg::WORD_W-1:0] rd_data
);
   import sbs_pkg::*;

   logic signed [WORD_W-1:0] table_mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         table_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= table_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sbs_search_ctrl.sv]
// ----------------------------------------------------------------------------
// Search controller
// Accepts load and search items, walks the bounds one probe per cycle and
// drives the result strobe.
// ----------------------------------------------------------------------------
module sbs_search_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [sbs_pkg::IDX_W-1:0]         req_entry_index,
   input  logic signed [sbs_pkg::WORD_W-1:0] req_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbs_pkg::CFG_W-1:0]         csr_table_size,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [sbs_pkg::POS_W-1:0]         rsp_position,
   output sbs_pkg::mem_req_type              mem_req,
   input  logic signed [sbs_pkg::WORD_W-1:0] rd_data
);
   import sbs_pkg::*;

   state_type                state_ff, state_in;
   logic [CFG_W-1:0]         size_ff, size_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic                     found_ff, found_in;
   logic [POS_W-1:0]         position_ff, position_in;
   logic [SIZE_W-1:0]        lo_ff, lo_in;
   logic [SIZE_W-1:0]        hip1_ff, hip1_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic signed [WORD_W-1:0] key_ff, key_in;

   logic              accept;
   logic [SIZE_W-1:0] size_sat;
   logic [SIZE_W-1:0] lo_cur, hip1_cur, span, mid_calc;
   logic              hit, more, finish;

   assign accept   = start & (state_ff == ST_IDLE);
   assign size_sat = (size_ff > CFG_W'(DEPTH)) ? SIZE_W'(DEPTH) : size_ff[SIZE_W-1:0];

   always_comb begin
      lo_cur   = lo_ff;
      hip1_cur = hip1_ff;
      hit      = 1'b0;
      if (rd_pend_ff) begin
         if (rd_data == key_ff) begin
            hit = 1'b1;
         end else if (rd_data < key_ff) begin
            lo_cur = {1'b0, mid_ff} + SIZE_W'(1);
         end else begin
            hip1_cur = {1'b0, mid_ff};
         end
      end
      more     = lo_cur < hip1_cur;
      span     = hip1_cur - lo_cur - SIZE_W'(1);
      mid_calc = lo_cur + (span >> 1);
      finish   = hit | ~more;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_SEARCH) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy            = (state_ff == ST_SEARCH);
      csr_ready       = 1'b1;
      size_in         = (csr_valid && csr_ready) ? csr_table_size : size_ff;
      mem_req.wr_en   = accept && req_mode == MODE_LOAD;
      mem_req.wr_addr = req_entry_index;
      mem_req.wr_data = req_value;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = mid_calc[IDX_W-1:0];
      lo_in           = lo_ff;
      hip1_in         = hip1_ff;
      mid_in          = mid_ff;
      key_in          = key_ff;
      rd_pend_in      = 1'b0;
      rsp_strobe_in   = 1'b0;
      found_in        = found_ff;
      position_in     = position_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_SEARCH) begin
               lo_in   = '0;
               hip1_in = size_sat;
               key_in  = req_value;
            end
         end
         ST_SEARCH: begin
            mem_req.rd_en = ~finish;
            rd_pend_in    = ~finish;
            lo_in         = lo_cur;
            hip1_in       = hip1_cur;
            mid_in        = mid_calc[IDX_W-1:0];
            rsp_strobe_in = finish;
            found_in      = hit;
            position_in   = hit ? mid_ff[POS_W-1:0] : '0;
         end
         default: begin
            rd_pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         size_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hip1_ff     <= hip1_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      position_ff <= position_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;

endmodule

[src/sorted_table_binary_search_unit.sv]
// ----------------------------------------------------------------------------
// Sorted table binary search unit
// A load item does not raise busy. A search item keeps busy high while it sets up
// and probes the table, one probe per cycle, and its result strobe is high in the
// first cycle with busy low. The receiver cannot stall. Reset clears the control
// state and the table size; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_mode,
   input  logic [sbs_pkg::IDX_W-1:0]         req_entry_index,
   input  logic signed [sbs_pkg::WORD_W-1:0] req_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbs_pkg::CFG_W-1:0]         csr_table_size,
   output logic                              rsp_strobe,
   output logic                              rsp_found,
   output logic [sbs_pkg::POS_W-1:0]         rsp_position
);
   import sbs_pkg::*;

   mem_req_type              mem_req;
   logic signed [WORD_W-1:0] rd_data;

   sbs_search_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_table_size  (csr_table_size),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .mem_req         (mem_req),
      .rd_data         (rd_data)
   );

   sbs_table_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
